// ===== rtl/core/tce_pkg.sv =====
`default_nettype none

package tce_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int USED_ROWS = ROWS - 1;
  localparam int CELLS     = COLUMNS * USED_ROWS;

  // field and index widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int OFS_W  = 11;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  // control characters and constants
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam int         TAB_STEP   = 8;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // screen memory access
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] wdata;
  } mem_req_t;

  // one result item
  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [OFS_W-1:0] cursor_offset;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic             scrolled;
  } res_t;

  function automatic logic [COL_W-1:0] clamp_col(logic [COL_W-1:0] c);
    return (c > COL_W'(COLUMNS - 1)) ? COL_W'(COLUMNS - 1) : c;
  endfunction

  function automatic logic [ROW_W-1:0] clamp_row(logic [ROW_W-1:0] r);
    return (r > ROW_W'(USED_ROWS - 1)) ? ROW_W'(USED_ROWS - 1) : r;
  endfunction

  // logical row to physical row of the circular row store
  function automatic logic [ROW_W-1:0] phys_row(logic [ROW_W-1:0] r, logic [ROW_W-1:0] base);
    logic [ROW_W:0] s;
    s = {1'b0, r} + {1'b0, base};
    if (s >= (ROW_W + 1)'(USED_ROWS)) begin
      s = s - (ROW_W + 1)'(USED_ROWS);
    end
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  function automatic logic [OFS_W-1:0] cursor_ofs(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return OFS_W'(r) * OFS_W'(COLUMNS) + OFS_W'(c);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tce_ram.sv =====
`default_nettype none

module tce_ram (
  input  wire logic                       clk_i,
  input  wire tce_pkg::mem_req_t          req_i,
  output logic [tce_pkg::CELL_W-1:0]      rdata_o
);
  import tce_pkg::*;

  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
  end

  // registered read port, data holds until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tce_ctrl.sv =====
`default_nettype none

module tce_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [7:0]                  char_code_i,
  input  wire logic [tce_pkg::COL_W-1:0]   col_i,
  input  wire logic [tce_pkg::ROW_W-1:0]   row_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [7:0]                  cfg_wdata_i,
  output tce_pkg::mem_req_t                mem_req_o,
  input  wire logic [tce_pkg::CELL_W-1:0]  mem_rdata_i,
  output logic                             res_valid_o,
  input  wire logic                        res_take_i,
  output tce_pkg::res_t                    res_o
);
  import tce_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_SWEEP,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [COL_W-1:0]      cur_col_q;
  logic [ROW_W-1:0]      cur_row_q;
  logic [ROW_W-1:0]      base_q;
  logic [USED_ROWS-1:0]  row_vld_q;
  logic [7:0]            attr_q;
  logic                  scrolled_q;
  logic                  is_read_q;
  logic                  vld_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [ROW_W-1:0]      prow_q;
  logic [COL_W-1:0]      col_q;
  logic [7:0]            ch_q;
  logic [COL_W-1:0]      sweep_q;

  logic                  accept;
  op_e                   op;
  logic [COL_W-1:0]      in_col_c;
  logic [ROW_W-1:0]      in_row_c;
  logic [ROW_W-1:0]      cur_prow;
  logic [ROW_W-1:0]      rd_prow;
  logic                  printable;
  logic                  is_bs;
  logic                  bs_move;
  logic [7:0]            col_w;
  logic [ROW_W:0]        row_w;
  logic                  scroll;
  logic [COL_W-1:0]      put_col;
  logic [ROW_W-1:0]      put_row;
  logic [ADDR_W-1:0]     put_addr;
  logic [ADDR_W-1:0]     bs_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ROW_W-1:0]      base_next;

  assign accept     = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign op         = op_e'(op_i);
  assign in_col_c   = clamp_col(col_i);
  assign in_row_c   = clamp_row(row_i);
  assign cur_prow   = phys_row(cur_row_q, base_q);
  assign rd_prow    = phys_row(in_row_c, base_q);
  assign is_bs      = (char_code_i == CH_BS);
  assign bs_move    = is_bs && (cur_col_q != '0);
  assign printable  = !(is_bs || (char_code_i == CH_TAB) ||
                        (char_code_i == CH_LF) || (char_code_i == CH_CR));
  assign put_addr   = cell_addr(cur_prow, cur_col_q);
  assign bs_addr    = cell_addr(cur_prow, COL_W'(cur_col_q - COL_W'(1)));
  assign rd_addr    = cell_addr(rd_prow, in_col_c);
  assign base_next  = (base_q == ROW_W'(USED_ROWS - 1)) ? '0 : ROW_W'(base_q + ROW_W'(1));

  // cursor after a put char
  always_comb begin
    col_w = {1'b0, cur_col_q};
    row_w = {1'b0, cur_row_q};
    case (char_code_i)
      CH_BS: begin
        if (cur_col_q != '0) begin
          col_w = col_w - 8'd1;
        end
      end
      CH_TAB: col_w = (col_w + 8'(TAB_STEP)) & ~8'(TAB_STEP - 1);
      CH_CR:  col_w = '0;
      CH_LF: begin
        col_w = '0;
        row_w = row_w + (ROW_W + 1)'(1);
      end
      default: col_w = col_w + 8'd1;
    endcase
    if (col_w >= 8'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + (ROW_W + 1)'(1);
    end
    scroll = (row_w >= (ROW_W + 1)'(USED_ROWS));
    if (scroll) begin
      row_w = (ROW_W + 1)'(USED_ROWS - 1);
    end
    put_col = col_w[COL_W-1:0];
    put_row = row_w[ROW_W-1:0];
  end

  // memory requests; accesses never overlap since one item runs at a time
  always_comb begin
    mem_req_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_PUT) begin
            if (printable && row_vld_q[cur_prow]) begin
              mem_req_o.we    = 1'b1;
              mem_req_o.addr  = put_addr;
              mem_req_o.wdata = {attr_q, char_code_i};
            end else if (bs_move) begin
              mem_req_o.re   = 1'b1;
              mem_req_o.addr = bs_addr;
            end
          end else if (op == OP_READ) begin
            mem_req_o.re   = 1'b1;
            mem_req_o.addr = rd_addr;
          end
        end
      end
      ST_WAIT: begin
        // backspace keeps the attribute, an unwritten row already reads as zero
        mem_req_o.we    = vld_q;
        mem_req_o.addr  = addr_q;
        mem_req_o.wdata = {mem_rdata_i[15:8], 8'h00};
      end
      ST_SWEEP: begin
        // zero a fresh row, dropping the pending character into its column
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = cell_addr(prow_q, sweep_q);
        mem_req_o.wdata = (sweep_q == col_q) ? {attr_q, ch_q} : '0;
      end
      ST_DONE: begin
        mem_req_o = '0;
      end
      default: mem_req_o = '0;
    endcase
  end

  // sequencer, cursor, row map and row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      base_q     <= '0;
      row_vld_q  <= '0;
      attr_q     <= ATTR_RESET;
      scrolled_q <= 1'b0;
      is_read_q  <= 1'b0;
      vld_q      <= 1'b0;
      addr_q     <= '0;
      prow_q     <= '0;
      col_q      <= '0;
      ch_q       <= '0;
      sweep_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            is_read_q  <= (op == OP_READ);
            scrolled_q <= (op == OP_PUT) && scroll;
            unique case (op)
              OP_PUT: begin
                cur_col_q <= put_col;
                cur_row_q <= put_row;
                if (scroll) begin
                  // the old top row becomes the new bottom row
                  base_q            <= base_next;
                  row_vld_q[base_q] <= 1'b0;
                end
                if (printable && !row_vld_q[cur_prow]) begin
                  prow_q  <= cur_prow;
                  col_q   <= cur_col_q;
                  ch_q    <= char_code_i;
                  sweep_q <= '0;
                  state_q <= ST_SWEEP;
                end else if (bs_move) begin
                  addr_q  <= bs_addr;
                  vld_q   <= row_vld_q[cur_prow];
                  state_q <= ST_WAIT;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              OP_MOVE: begin
                cur_col_q <= in_col_c;
                cur_row_q <= in_row_c;
                state_q   <= ST_DONE;
              end
              OP_CLEAR: begin
                cur_col_q <= '0;
                cur_row_q <= '0;
                base_q    <= '0;
                row_vld_q <= '0;
                state_q   <= ST_DONE;
              end
              OP_READ: begin
                vld_q   <= row_vld_q[rd_prow];
                state_q <= ST_DONE;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_WAIT: begin
          state_q <= ST_DONE;
        end
        ST_SWEEP: begin
          sweep_q <= COL_W'(sweep_q + COL_W'(1));
          if (sweep_q == COL_W'(COLUMNS - 1)) begin
            row_vld_q[prow_q] <= 1'b1;
            state_q           <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // result, cell bytes come straight from the held read data
  assign res_valid_o          = (state_q == ST_DONE);
  assign res_o.cursor_col     = cur_col_q;
  assign res_o.cursor_row     = cur_row_q;
  assign res_o.cursor_offset  = cursor_ofs(cur_row_q, cur_col_q);
  assign res_o.cell_char      = (is_read_q && vld_q) ? mem_rdata_i[7:0] : 8'h00;
  assign res_o.cell_attr      = (is_read_q && vld_q) ? mem_rdata_i[15:8] : 8'h00;
  assign res_o.scrolled       = scrolled_q;

  // checks
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.we && mem_req_o.re))
    else $error("screen memory read and write in one cycle");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req_o.we || mem_req_o.re) |-> (mem_req_o.addr < ADDR_W'(CELLS)))
    else $error("screen memory address out of range");

  a_sweep_marks_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && sweep_q == COL_W'(COLUMNS - 1)) |=> row_vld_q[$past(prow_q)])
    else $error("swept row not marked valid");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q < COL_W'(COLUMNS)) && (cur_row_q < ROW_W'(USED_ROWS)) &&
    (base_q < ROW_W'(USED_ROWS)))
    else $error("cursor or row base out of range");

  a_scroll_only_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op != OP_PUT) |=> !scrolled_q)
    else $error("scroll flagged for an item other than put char");

endmodule

`default_nettype wire

// ===== rtl/core/text_console_engine.sv =====
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   op_i, char_code_i, col_i, row_i
// out       output     out_valid_o / out_stall_i cursor_col_o, cursor_row_o,
//                                                cursor_offset_o, cell_char_o,
//                                                cell_attr_o, scrolled_o
// cfg       input      cfg_we_i                  cfg_wdata_i (text attribute)
//
// One request is in work at a time. Move, clear, read and most put chars go
// from idle straight to done; a backspace that moves the cursor reads its cell
// and rewrites it from a wait state (read then write on the one memory port),
// and the first character written into a blank row sweeps that row through
// the write port first. Scroll and clear only touch the row map and per-row
// valid bits, sweeping no memory; reset is immediate, with no clearing pass.
// A result waiting in the output register under out_stall_i does not hold off
// the next request; a second result waits in the control until the slot frees.

module text_console_engine (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  op_i,
  input  wire logic [7:0]                  char_code_i,
  input  wire logic [tce_pkg::COL_W-1:0]   col_i,
  input  wire logic [tce_pkg::ROW_W-1:0]   row_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [tce_pkg::COL_W-1:0]        cursor_col_o,
  output logic [tce_pkg::ROW_W-1:0]        cursor_row_o,
  output logic [tce_pkg::OFS_W-1:0]        cursor_offset_o,
  output logic [7:0]                       cell_char_o,
  output logic [7:0]                       cell_attr_o,
  output logic                             scrolled_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [7:0]                  cfg_wdata_i
);
  import tce_pkg::*;

  mem_req_t          mem_req;
  logic [CELL_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_take;
  res_t              res;
  logic              out_valid_q;
  res_t              out_q;

  tce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  tce_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register, loads when empty or being drained
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = out_q.cursor_col;
  assign cursor_row_o    = out_q.cursor_row;
  assign cursor_offset_o = out_q.cursor_offset;
  assign cell_char_o     = out_q.cell_char;
  assign cell_attr_o     = out_q.cell_attr;
  assign scrolled_o      = out_q.scrolled;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tce_pkg::*;

  localparam int SETTLE_CYCLES = COLUMNS + 10;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 170;

  // one request with an optional hand-typed result
  typedef struct packed {
    op_e              op;
    logic [7:0]       ch;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    bit               typed;
    res_t             want;
  } console_req_t;

  // clock and reset
  logic clk    = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // request side
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [1:0]       op_d      = '0;
  logic [7:0]       ch_d      = '0;
  logic [COL_W-1:0] col_d     = '0;
  logic [ROW_W-1:0] row_d     = '0;

  // result side
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [OFS_W-1:0] cursor_offset;
  logic [7:0]       cell_char;
  logic [7:0]       cell_attr;
  logic             scrolled;

  // attribute register port
  logic       cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  text_console_engine dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op_d),
    .char_code_i     (ch_d),
    .col_i           (col_d),
    .row_i           (row_d),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .cursor_col_o    (cursor_col),
    .cursor_row_o    (cursor_row),
    .cursor_offset_o (cursor_offset),
    .cell_char_o     (cell_char),
    .cell_attr_o     (cell_attr),
    .scrolled_o      (scrolled),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  // console model state
  logic [15:0] screen_model [CELLS];
  int unsigned cur_c;
  int unsigned cur_r;
  logic [7:0]  attr_model;

  res_t         cursor_reports [$];
  console_req_t directed_reqs [$];

  int  err_count    = 0;
  int  sent_count   = 0;
  int  result_count = 0;
  int  scroll_count = 0;
  int  read_count   = 0;
  int  stall_left   = 0;
  bit  quiet        = 1'b0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic check_field(string what, int got, int want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  // advance the console model by one request and build its cursor report
  task automatic console_apply(op_e op, logic [7:0] ch, logic [COL_W-1:0] c,
                               logic [ROW_W-1:0] r, output res_t res);
    int unsigned cc;
    int unsigned rr;
    logic [15:0] cell_val;
    res = '0;
    cc  = (c > COLUMNS - 1) ? COLUMNS - 1 : c;
    rr  = (r > USED_ROWS - 1) ? USED_ROWS - 1 : r;
    case (op)
      OP_PUT: begin
        if (ch == CH_BS) begin
          // backspace never reaches into the previous row
          if (cur_c > 0) begin
            cur_c--;
            screen_model[cur_r * COLUMNS + cur_c][7:0] = 8'h00;
          end
        end else if (ch == CH_TAB) begin
          cur_c = (cur_c + TAB_STEP) / TAB_STEP * TAB_STEP;
        end else if (ch == CH_CR) begin
          cur_c = 0;
        end else if (ch == CH_LF) begin
          cur_c = 0;
          cur_r++;
        end else begin
          screen_model[cur_r * COLUMNS + cur_c] = {attr_model, ch};
          cur_c++;
        end
        if (cur_c >= COLUMNS) begin
          cur_c = 0;
          cur_r++;
        end
        // scroll up one row and blank the bottom one
        if (cur_r >= USED_ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_model[i] = '0;
          end
          cur_r        = USED_ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      OP_MOVE: begin
        cur_c = cc;
        cur_r = rr;
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          screen_model[i] = '0;
        end
        cur_c = 0;
        cur_r = 0;
      end
      default: begin
        cell_val      = screen_model[rr * COLUMNS + cc];
        res.cell_char = cell_val[7:0];
        res.cell_attr = cell_val[15:8];
      end
    endcase
    res.cursor_col    = COL_W'(cur_c);
    res.cursor_row    = ROW_W'(cur_r);
    res.cursor_offset = OFS_W'(cur_r * COLUMNS + cur_c);
  endtask

  // directed row; a typed row carries its cursor report, cells read as zero
  function automatic console_req_t req(op_e op, logic [7:0] ch, int c, int r,
                                       bit typed = 1'b0, int wc = 0, int wr = 0,
                                       int wo = 0, bit ws = 1'b0);
    console_req_t rq;
    rq.op                 = op;
    rq.ch                 = ch;
    rq.col                = COL_W'(c);
    rq.row                = ROW_W'(r);
    rq.typed              = typed;
    rq.want               = '0;
    rq.want.cursor_col    = COL_W'(wc);
    rq.want.cursor_row    = ROW_W'(wr);
    rq.want.cursor_offset = OFS_W'(wo);
    rq.want.scrolled      = ws;
    return rq;
  endfunction

  // random request, weighted toward text and cursor moves near the bottom
  task automatic random_request(output console_req_t rq);
    int unsigned pick;
    int unsigned sub;
    pick     = $urandom_range(0, 99);
    sub      = $urandom_range(0, 9);
    rq       = '0;
    rq.ch    = 8'($urandom_range(0, 255));
    rq.col   = COL_W'($urandom_range(0, 127));
    rq.row   = ROW_W'($urandom_range(0, 31));
    if (pick < 60) begin
      rq.op = OP_PUT;
      case (sub)
        0, 1:    rq.ch = CH_BS;
        2:       rq.ch = CH_TAB;
        3:       rq.ch = CH_CR;
        4:       rq.ch = CH_LF;
        default: ;
      endcase
    end else if (pick < 78) begin
      rq.op = OP_MOVE;
      if (sub < 3) begin
        rq.col = COL_W'($urandom_range(COLUMNS - 8, COLUMNS - 1));
        rq.row = ROW_W'($urandom_range(USED_ROWS - 4, USED_ROWS - 1));
      end else if (sub < 8) begin
        rq.col = COL_W'($urandom_range(0, COLUMNS - 1));
        rq.row = ROW_W'($urandom_range(0, USED_ROWS - 1));
      end
    end else if (pick < 97) begin
      rq.op = OP_READ;
      if (sub < 8) begin
        rq.col = COL_W'($urandom_range(0, COLUMNS - 1));
        rq.row = ROW_W'($urandom_range(0, USED_ROWS - 1));
      end
    end else begin
      rq.op = OP_CLEAR;
    end
  endtask

  // present one request, hold it until taken, then record its expected report
  task automatic send_request(console_req_t rq);
    int   gap;
    res_t exp;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    op_d     <= rq.op;
    ch_d     <= rq.ch;
    col_d    <= rq.col;
    row_d    <= rq.row;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    console_apply(rq.op, rq.ch, rq.col, rq.row, exp);
    cursor_reports.push_back(rq.typed ? rq.want : exp);
    sent_count++;
    if (rq.op == OP_READ) begin
      read_count++;
    end
  endtask

  // stop sending and wait until every report is back and the block is quiet
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (cursor_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] value);
    drain_and_settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we     <= 1'b0;
    attr_model = value;
  endtask

  // random receiver stall bursts
  always @(negedge clk) begin
    if (!rst_ni || quiet) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted report with the oldest expected one
  always @(posedge clk) begin : check_reports
    res_t want;
    if (rst_ni && out_valid && !out_stall) begin
      result_count++;
      if (cursor_reports.size() == 0) begin
        report_mismatch("report with no request outstanding, offset", cursor_offset, 0);
      end else begin
        want = cursor_reports.pop_front();
        check_field("cursor_col", cursor_col, want.cursor_col);
        check_field("cursor_row", cursor_row, want.cursor_row);
        check_field("cursor_offset", cursor_offset, want.cursor_offset);
        check_field("cell_char", cell_char, want.cell_char);
        check_field("cell_attr", cell_attr, want.cell_attr);
        check_field("scrolled", scrolled, want.scrolled);
        if (want.scrolled) begin
          scroll_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("timeout waiting for the console");
    $display("tb failed");
    $finish;
  end

  initial begin
    console_req_t rq;
    logic [7:0]   phase_attr;

    for (int i = 0; i < CELLS; i++) begin
      screen_model[i] = '0;
    end
    cur_c      = 0;
    cur_r      = 0;
    attr_model = ATTR_RESET;

    // reset state, clamping, wrap and scroll at the corner
    directed_reqs.push_back(req(OP_READ, 8'h00, 0, 0, 1'b1, 0, 0, 0));
    directed_reqs.push_back(req(OP_MOVE, 8'h00, 127, 31, 1'b1, 79, 23, 1919));
    directed_reqs.push_back(req(OP_READ, 8'h00, 127, 31, 1'b1, 79, 23, 1919));
    directed_reqs.push_back(req(OP_PUT, 8'h41, 0, 0, 1'b1, 0, 23, 1840, 1'b1));
    directed_reqs.push_back(req(OP_READ, 8'h00, 79, 22));
    directed_reqs.push_back(req(OP_MOVE, 8'h00, 0, 0, 1'b1, 0, 0, 0));
    // backspace at column zero does nothing
    directed_reqs.push_back(req(OP_PUT, CH_BS, 0, 0, 1'b1, 0, 0, 0));
    // character byte extremes, then control characters
    directed_reqs.push_back(req(OP_PUT, 8'hFF, 127, 31));
    directed_reqs.push_back(req(OP_PUT, 8'h00, 0, 0));
    directed_reqs.push_back(req(OP_PUT, CH_BS, 0, 0));
    directed_reqs.push_back(req(OP_READ, 8'h00, 0, 0));
    directed_reqs.push_back(req(OP_PUT, CH_TAB, 0, 0));
    directed_reqs.push_back(req(OP_PUT, CH_TAB, 0, 0));
    directed_reqs.push_back(req(OP_PUT, CH_CR, 0, 0));
    directed_reqs.push_back(req(OP_PUT, CH_LF, 0, 0));
    // tab past the last column wraps, LF and tab on the bottom row scroll
    directed_reqs.push_back(req(OP_MOVE, 8'h00, 78, 5));
    directed_reqs.push_back(req(OP_PUT, CH_TAB, 0, 0));
    directed_reqs.push_back(req(OP_MOVE, 8'h00, 79, 23));
    directed_reqs.push_back(req(OP_PUT, CH_LF, 0, 0));
    directed_reqs.push_back(req(OP_MOVE, 8'h00, 79, 23));
    directed_reqs.push_back(req(OP_PUT, CH_TAB, 0, 0));
    directed_reqs.push_back(req(OP_READ, 8'h00, 79, 21));
    directed_reqs.push_back(req(OP_CLEAR, 8'h00, 127, 31, 1'b1, 0, 0, 0));
    directed_reqs.push_back(req(OP_READ, 8'h00, 79, 22, 1'b1, 0, 0, 0));
    directed_reqs.push_back(req(OP_MOVE, 8'h00, 80, 24, 1'b1, 79, 23, 1919));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (directed_reqs[i]) begin
      send_request(directed_reqs[i]);
    end

    // random phases, each under its own attribute, the last without idling
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_attr = 8'h00;
        1:       phase_attr = 8'hFF;
        PHASES - 1: phase_attr = ATTR_RESET;
        default: phase_attr = 8'($urandom_range(1, 254));
      endcase
      write_attr(phase_attr);
      if (phase == PHASES - 1) begin
        quiet = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        random_request(rq);
        send_request(rq);
      end
    end

    drain_and_settle();

    $display("sent %0d requests over %0d attribute settings, %0d reports checked",
             sent_count, PHASES, result_count);
    $display("%0d of them scrolled the screen, %0d were cell reads", scroll_count, read_count);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tce_pkg.sv
rtl/core/tce_ram.sv
rtl/core/tce_ctrl.sv
rtl/core/text_console_engine.sv
tb/tb.sv
